>>> rtl/cplg_pkg.sv
// Shared types, constants and register indexes of the CPU performance level governor.
package cplg_pkg;

  // Field widths of the request items
  localparam int unsigned CPU_W      = 6;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned REQ_W      = 11;
  localparam int unsigned CAP_W      = 32;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Defaults of the top level parameters
  localparam int unsigned NUM_CPUS_DEF = 64;
  localparam int unsigned PERF_ONE_DEF = 1024;

  // Only this many CPUs can be named by the cpu_id field
  localparam int unsigned CPU_SPAN = 1 << CPU_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_CAP = CFG_IDX_W'(1);

  // Register reset values
  localparam logic             ENABLE_RST    = 1'b1;
  localparam logic [CAP_W-1:0] SLICE_CAP_RST = CAP_W'(20000000);

  // Commands carried by an input request
  localparam logic CMD_REPORT  = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Input request payload
  typedef struct packed {
    logic              command;
    logic [CPU_W-1:0]  cpu_id;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] run_time;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic             request_valid;
    logic [REQ_W-1:0] perf_request;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic look;
    logic div_start;
    logic fold;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic usable;
    logic is_request;
    logic elapsed_zero;
    logic div_done;
    logic slot_free;
  } ctl_sts_t;

endpackage

>>> rtl/cpu_perf_level_governor.sv
// Top level of the per-CPU performance level governor.
//
// Input channel (in_valid/in_ready/in_data) carries one request: a run time
// report (command 0) or a level request (command 1) for one CPU. Every
// request produces exactly one result on the output channel
// (out_valid/out_ready/out_data); only an enabled level request for a CPU
// in range has request_valid set, all other results are zero.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
// the enable bit (index 0) and the run time cap (index 1); it is always ready.
// One request is handled at a time. A level request and an ignored report
// go from the look step straight to the result register; a report with zero
// elapsed time also passes the multiply step. A full report then runs the
// bit-serial divider that forms run * PERF_ONE / elapsed, then the fold step.
// The next request can be taken in the cycle after the result is loaded,
// even if the receiver has not yet taken the result; when the receiver stalls
// with a result still held, the block stops after finishing the next request.
// Reset clears the per-CPU state to zero through valid bits, restores the
// register defaults and empties the output register.
module cpu_perf_level_governor #(
  parameter int unsigned NUM_CPUS = cplg_pkg::NUM_CPUS_DEF,
  parameter int unsigned PERF_ONE = cplg_pkg::PERF_ONE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cplg_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cplg_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cplg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cplg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cplg_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer for one request at a time.
  cplg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // State, arithmetic and result register.
  cplg_dp #(
    .NUM_CPUS (NUM_CPUS),
    .PERF_ONE (PERF_ONE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign cfg_ready = 1'b1;

endmodule

>>> rtl/cplg_div.sv
// Restoring divider that produces one quotient bit per cycle.
module cplg_div #(
  parameter int unsigned DVD_W = 43
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,
  input  logic [cplg_pkg::TIME_W-1:0] divisor,
  output logic                       done,
  output logic [DVD_W-1:0]           quotient
);
  import cplg_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [TIME_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   diff;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_sh   = {rem_r, quo_r[DVD_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[TIME_W]) begin
        rem_nxt = diff[TIME_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[TIME_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/cplg_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module cplg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cplg_pkg::ctl_sts_t sts,
  output cplg_pkg::ctl_cmd_t cmd
);
  import cplg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FOLD = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (sts.usable && !sts.is_request) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        if (sts.elapsed_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // The fold step only follows a finished division.
  a_fold_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD) |-> $past(sts.div_done))
    else $error("fold step entered without a finished division");

  // A report with zero elapsed time never starts the divider.
  a_no_div_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && sts.elapsed_zero) |=> (state_r == S_DONE))
    else $error("divider path taken with zero elapsed time");

endmodule

>>> rtl/cplg_dp.sv
// Datapath: configuration, per-CPU state memory, level arithmetic and result register.
module cplg_dp #(
  parameter int unsigned NUM_CPUS = cplg_pkg::NUM_CPUS_DEF,
  parameter int unsigned PERF_ONE = cplg_pkg::PERF_ONE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cplg_pkg::in_item_t            in_data,
  input  logic                          cfg_valid,
  input  logic [cplg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cplg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cplg_pkg::out_item_t           out_data,
  input  cplg_pkg::ctl_cmd_t            cmd,
  output cplg_pkg::ctl_sts_t            sts
);
  import cplg_pkg::*;

  localparam int unsigned MEM_DEPTH = (NUM_CPUS < CPU_SPAN) ? NUM_CPUS : CPU_SPAN;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned LVL_W     = $clog2(PERF_ONE + 1);
  localparam int unsigned PRD_W     = CAP_W + LVL_W;
  localparam int unsigned HI_TH     = PERF_ONE - PERF_ONE / 4;
  localparam int unsigned LO_TH     = PERF_ONE / 4;
  localparam int unsigned HALF      = PERF_ONE / 2;

  // Configuration registers
  logic             enable_r;
  logic [CAP_W-1:0] slice_cap_r;

  // Captured request
  logic              command_r;
  logic [AW-1:0]     addr_r;
  logic [TIME_W-1:0] now_r;
  logic [CAP_W-1:0]  run_cap_r;
  logic              usable_r;

  // Per-CPU state memory and its valid bits
  logic [TIME_W-1:0] mem_time [MEM_DEPTH];
  logic [LVL_W-1:0]  mem_lvl  [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [TIME_W-1:0] rd_time_r;
  logic [LVL_W-1:0]  rd_lvl_r;
  logic              rd_vld_r;

  // Arithmetic and result
  logic [TIME_W-1:0] elapsed_r;
  logic [TIME_W-1:0] prev_time;
  logic [LVL_W-1:0]  prev_lvl;
  logic [PRD_W-1:0]  product;
  logic              div_done;
  logic [PRD_W-1:0]  quotient;
  logic [LVL_W-1:0]  inst_lvl;
  logic [LVL_W-1:0]  fold_lvl;
  logic [LVL_W-1:0]  pick_lvl;
  out_item_t         res_r;
  out_item_t         out_r;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       cpu_ext;
  logic [AW-1:0]     in_addr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ENABLE_RST;
      slice_cap_r <= SLICE_CAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:    enable_r    <= cfg_data[0];
        REG_SLICE_CAP: slice_cap_r <= cfg_data[CAP_W-1:0];
        default:       ;
      endcase
    end
  end

  assign cpu_ext = 32'(in_data.cpu_id);
  assign in_addr = cpu_ext[AW-1:0];

  // Capture the request and cap its run time.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      command_r <= in_data.command;
      addr_r    <= in_addr;
      now_r     <= in_data.now;
      usable_r  <= enable_r && (cpu_ext < NUM_CPUS);
      if (in_data.run_time > TIME_W'(slice_cap_r)) begin
        run_cap_r <= slice_cap_r;
      end else begin
        run_cap_r <= in_data.run_time[CAP_W-1:0];
      end
    end
  end

  // Memory read on accept, write on fold.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_time_r <= mem_time[in_addr];
      rd_lvl_r  <= mem_lvl[in_addr];
    end
    if (cmd.fold) begin
      mem_time[addr_r] <= now_r;
      mem_lvl[addr_r]  <= fold_lvl;
    end
  end

  // Valid bits stand in for the reset value of zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_vld_r <= vld_r[in_addr];
      end
      if (cmd.fold) begin
        vld_r[addr_r] <= 1'b1;
      end
    end
  end

  assign prev_time = rd_vld_r ? rd_time_r : '0;
  assign prev_lvl  = rd_vld_r ? rd_lvl_r  : '0;

  // Level selection for a request.
  always_comb begin
    if (32'(prev_lvl) >= HI_TH) begin
      pick_lvl = LVL_W'(PERF_ONE);
    end else if (32'(prev_lvl) <= LO_TH) begin
      pick_lvl = LVL_W'(HALF);
    end else begin
      pick_lvl = prev_lvl;
    end
  end

  // Elapsed time and the pending result.
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      elapsed_r <= now_r - prev_time;
      if (usable_r && command_r == CMD_REQUEST) begin
        res_r.request_valid <= 1'b1;
        res_r.perf_request  <= REQ_W'(pick_lvl);
      end else begin
        res_r <= '0;
      end
    end
  end

  // Scaled run time feeds the divider register directly.
  assign product = PRD_W'(run_cap_r) * PRD_W'(PERF_ONE);

  cplg_div #(
    .DVD_W(PRD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (elapsed_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp the instant level and fold it into the moving average.
  always_comb begin
    if (quotient > PRD_W'(PERF_ONE)) begin
      inst_lvl = LVL_W'(PERF_ONE);
    end else begin
      inst_lvl = quotient[LVL_W-1:0];
    end
    fold_lvl = (prev_lvl - (prev_lvl >> 2)) + (inst_lvl >> 2);
  end

  // Output register decouples the result from the next request.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller.
  assign sts.usable       = usable_r;
  assign sts.is_request   = (command_r == CMD_REQUEST);
  assign sts.elapsed_zero = (elapsed_r == '0);
  assign sts.div_done     = div_done;
  assign sts.slot_free    = !out_valid_r || out_ready;

  // A result without a request carries a zero level.
  a_zero_when_idle_req: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.request_valid) |-> (out_r.perf_request == '0))
    else $error("result without a request carries a nonzero level");

  // The smoothed level written back never exceeds full scale.
  a_fold_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |-> (32'(fold_lvl) <= PERF_ONE))
    else $error("smoothed level above full scale");

  // A loaded result is presented in the next cycle.
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule
